>>> hw/rtl/disk_sector_address_translator_macros.svh
// Assertion macros used by the verification file of the sector translator.
// Expects signals clk and rst_n in the scope of each use.
`ifndef DISK_SECTOR_ADDRESS_TRANSLATOR_MACROS_SVH
`define DISK_SECTOR_ADDRESS_TRANSLATOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DSAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sector translator check failed");

// Check a property on every clock edge, reset included.
`define DSAT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("sector translator check failed");

`endif

>>> hw/rtl/dsat_pkg.sv
// Shared types and constants of the sector address translator.
// No dependencies; used by the divider cell, the top level and the checker.
package dsat_pkg;

  localparam int ADDR_W        = 28;
  localparam int DIV_W         = 8;
  localparam int STEPS_PER_CELL = 4;
  localparam int CELLS_PER_DIV = ADDR_W / STEPS_PER_CELL;
  localparam int NUM_CELLS     = 2 * CELLS_PER_DIV;

  localparam logic [2:0] LBA_SELECT = 3'b111;
  localparam logic [2:0] CHS_SELECT = 3'b101;

  localparam logic [7:0] SPT_RESET   = 8'd63;
  localparam logic [4:0] HEADS_RESET = 5'd16;

  typedef enum logic [2:0] {
    REG_D0_LBA   = 3'd0,
    REG_D0_SPT   = 3'd1,
    REG_D0_HEADS = 3'd2,
    REG_D1_LBA   = 3'd3,
    REG_D1_SPT   = 3'd4,
    REG_D1_HEADS = 3'd5
  } dsat_reg_t;

  // Item as it travels down the divider chain.
  typedef struct packed {
    logic              drive;
    logic              lba;
    logic [ADDR_W-1:0] lin;       // original address, for LBA pass-through
    logic [ADDR_W-1:0] num;       // dividend bits out on top, quotient bits in below
    logic [DIV_W-1:0]  rem;       // running remainder
    logic [DIV_W-1:0]  dvs;       // divisor of the current division
    logic [DIV_W-1:0]  dvs_next;  // divisor of the second division
    logic [DIV_W-1:0]  srem;      // remainder of the first division
  } dsat_item_t;

endpackage

>>> hw/rtl/disk_sector_address_translator.sv
// Top level of the ATA sector address translator: LBA pass-through or CHS
// conversion by a chain of restoring-divider cells. Depends on dsat_pkg, dsat_cell.
//
//  channel | direction | payload
//  in_     | slave     | tdata[27:0] linear_sector, tuser[0] drive_select
//  out_    | master    | tdata sector/cyl_low/cyl_high/drive_head bytes,
//          |           | tuser[0] cylinder_overflow
//  cfg_    | write only| cfg_index selects register, cfg_wdata[7:0] value
//
// Throughput: one transfer per cycle on each side while out_ is not stalled.
// The chain holds 14 divider cells, each doing four quotient bits (seven cells
// divide by sectors per track, seven by heads).
// Reset (synchronous, rst_n low) empties the chain and restores the registers.
// A stall on out_ ripples back cell by cell; empty cells keep accepting, so the
// input side stalls only once every cell holds an item.
module disk_sector_address_translator
  import dsat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [27:0] linear_sector, [31:28] zero
  input  logic [0:0]  in_tuser,   // [0] drive_select
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] sector_byte, [15:8] cyl_low_byte,
                                  // [23:16] cyl_high_byte, [31:24] drive_head_byte
  output logic [0:0]  out_tuser,  // [0] cylinder_overflow
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  // Per-drive configuration registers.
  logic [1:0]       lba_mode_r;
  logic [DIV_W-1:0] spt_r   [2];
  logic [4:0]       heads_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_mode_r <= '0;
      spt_r[0]   <= SPT_RESET;
      spt_r[1]   <= SPT_RESET;
      heads_r[0] <= HEADS_RESET;
      heads_r[1] <= HEADS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_D0_LBA:   lba_mode_r[0] <= cfg_wdata[0];
        REG_D0_SPT:   spt_r[0]      <= cfg_wdata;
        REG_D0_HEADS: heads_r[0]    <= cfg_wdata[4:0];
        REG_D1_LBA:   lba_mode_r[1] <= cfg_wdata[0];
        REG_D1_SPT:   spt_r[1]      <= cfg_wdata;
        REG_D1_HEADS: heads_r[1]    <= cfg_wdata[4:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Links between cells: link i feeds cell i, cell i drives link i+1.
  dsat_item_t link_d   [NUM_CELLS+1];
  logic       link_v   [NUM_CELLS+1];
  logic       link_rdy [NUM_CELLS+1];

  // Load the chain: pick the drive's divisors and start with a clear remainder.
  always_comb begin
    link_d[0].drive    = in_tuser[0];
    link_d[0].lba      = lba_mode_r[in_tuser[0]];
    link_d[0].lin      = in_tdata[ADDR_W-1:0];
    link_d[0].num      = in_tdata[ADDR_W-1:0];
    link_d[0].rem      = '0;
    link_d[0].dvs      = spt_r[in_tuser[0]];
    link_d[0].dvs_next = {{(DIV_W-5){1'b0}}, heads_r[in_tuser[0]]};
    link_d[0].srem     = '0;
  end
  assign link_v[0]  = in_tvalid;
  assign in_tready  = link_rdy[0];

  genvar g;
  generate
    for (g = 0; g < NUM_CELLS; g++) begin : g_cell
      dsat_item_t cell_in;
      if (g == CELLS_PER_DIV) begin : g_swap
        // First division done: keep the track number as dividend, save the
        // sector remainder, and switch to the head count.
        always_comb begin
          cell_in      = link_d[g];
          cell_in.srem = link_d[g].rem;
          cell_in.rem  = '0;
          cell_in.dvs  = link_d[g].dvs_next;
        end
      end else begin : g_pass
        assign cell_in = link_d[g];
      end

      dsat_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_v[g]),
        .up_ready (link_rdy[g]),
        .up_data  (cell_in),
        .dn_valid (link_v[g+1]),
        .dn_ready (link_rdy[g+1]),
        .dn_data  (link_d[g+1])
      );
    end
  endgenerate

  // Format the task-file bytes from the last cell's register.
  dsat_item_t fin;
  logic [7:0] sector_byte;
  logic [7:0] cyl_low_byte;
  logic [7:0] cyl_high_byte;
  logic [7:0] drive_head_byte;
  logic       cylinder_overflow;

  assign fin = link_d[NUM_CELLS];

  always_comb begin
    if (fin.lba) begin
      sector_byte       = fin.lin[7:0];
      cyl_low_byte      = fin.lin[15:8];
      cyl_high_byte     = fin.lin[23:16];
      drive_head_byte   = {LBA_SELECT, fin.drive, fin.lin[27:24]};
      cylinder_overflow = 1'b0;
    end else begin
      // sector numbers count from one; a remainder of 255 wraps to zero
      sector_byte       = fin.srem + 8'd1;
      cyl_low_byte      = fin.num[7:0];
      cyl_high_byte     = fin.num[15:8];
      drive_head_byte   = {CHS_SELECT, fin.drive, fin.rem[3:0]};
      cylinder_overflow = |fin.num[ADDR_W-1:16];
    end
  end

  assign out_tvalid          = link_v[NUM_CELLS];
  assign link_rdy[NUM_CELLS] = out_tready;
  assign out_tdata           = {drive_head_byte, cyl_high_byte, cyl_low_byte, sector_byte};
  assign out_tuser           = cylinder_overflow;

endmodule

>>> hw/rtl/dsat_cell.sv
// One divider cell: a few restoring-division steps, then a pipeline register.
// Depends on dsat_pkg.
module dsat_cell
  import dsat_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  dsat_item_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output dsat_item_t dn_data
);

  logic       valid_r;
  dsat_item_t data_r;
  dsat_item_t data_nxt;

  always_comb begin
    logic [DIV_W:0] trial;
    data_nxt = up_data;
    for (int s = 0; s < STEPS_PER_CELL; s++) begin
      trial = {data_nxt.rem, data_nxt.num[ADDR_W-1]};
      if (trial >= {1'b0, data_nxt.dvs}) begin
        trial = trial - {1'b0, data_nxt.dvs};
        data_nxt.num = {data_nxt.num[ADDR_W-2:0], 1'b1};
      end else begin
        data_nxt.num = {data_nxt.num[ADDR_W-2:0], 1'b0};
      end
      // a zero divisor keeps only the low byte of the shifted-in dividend
      data_nxt.rem = trial[DIV_W-1:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> hw/rtl/dsat_checker.sv
// Port-level checks of the sector address translator, bound to the top level.
// Depends on dsat_pkg and disk_sector_address_translator_macros.svh.
`include "disk_sector_address_translator_macros.svh"

module dsat_checker
  import dsat_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic [2:0] sel_prefix;

  assign sel_prefix = out_tdata[31:29];

  // hold a stalled result
  `DSAT_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // a result carries one of the two select-byte prefixes
  `DSAT_ASSERT(a_select_prefix, out_tvalid |-> sel_prefix == CHS_SELECT || sel_prefix == LBA_SELECT)
  // overflow only in CHS results
  `DSAT_ASSERT(a_ovf_chs, out_tvalid && out_tuser[0] |-> sel_prefix == CHS_SELECT)
  // chain is empty right after reset
  `DSAT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind disk_sector_address_translator dsat_checker u_dsat_checker (.*);
